/* sv/ims_pkg.sv */
package ims_pkg;

    localparam int TARGET_FRAMES = 8;

    localparam logic [9:0]  TGT_UFRAMES    = 10'(TARGET_FRAMES * 8);
    localparam logic [15:0] SCHED_OFFSET   = 16'd32;
    localparam logic [23:0] DEFAULT_BUDGET = 24'd2048;
    localparam logic [23:0] BYTES_MAX      = 24'hffffff;

    localparam logic [1:0] ACT_START    = 2'd0;
    localparam logic [1:0] ACT_REQUEST  = 2'd1;
    localparam logic [1:0] ACT_COMPLETE = 2'd2;
    localparam logic [1:0] ACT_STOP     = 2'd3;

    localparam logic [2:0] CFG_INTERVAL_LOG2  = 3'd0;
    localparam logic [2:0] CFG_FRAME_PINNING  = 3'd1;
    localparam logic [2:0] CFG_THRESHOLD_RAW  = 3'd2;
    localparam logic [2:0] CFG_DIRECTION_IN   = 3'd3;
    localparam logic [2:0] CFG_PREFETCH_LIMIT = 3'd4;

    typedef struct packed {
        logic [3:0]  interval_log2;
        logic        frame_pinning;
        logic [3:0]  threshold_raw;
        logic        direction_in;
        logic [23:0] prefetch_limit;
    } cfg_t;

    typedef struct packed {
        logic [13:0] next_slot;
        logic [23:0] bytes_in_flight;
        logic [5:0]  threshold_uframes;
        logic [9:0]  td_target;
    } sched_state_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [13:0] frame_index;
        logic [23:0] byte_count;
        logic [9:0]  active_tds;
    } item_t;

    typedef struct packed {
        logic        granted;
        logic [10:0] frame_id;
    } grant_t;

endpackage

/* sv/ims_if.sv */
interface ims_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [13:0] frame_index;
    logic [23:0] byte_count;
    logic [9:0]  active_tds;

    modport source (output valid, action, frame_index, byte_count, active_tds, input ready);
    modport sink   (input valid, action, frame_index, byte_count, active_tds, output ready);
endinterface

interface ims_res_if;
    logic        valid;
    logic        ready;
    logic        granted;
    logic [10:0] frame_id;
    logic [13:0] slot_now;
    logic [23:0] bytes_now;
    logic [9:0]  target_now;

    modport source (output valid, granted, frame_id, slot_now, bytes_now, target_now,
                    input ready);
    modport sink   (input valid, granted, frame_id, slot_now, bytes_now, target_now,
                    output ready);
endinterface

/* sv/ims_step.sv */
module ims_step
    import ims_pkg::*;
(
    input  cfg_t         cfg,
    input  sched_state_t state,
    input  item_t        item,
    output sched_state_t state_next,
    output grant_t       grant
);

    function automatic logic [13:0] earliest_slot(
        input logic [13:0] mf,
        input logic [5:0]  thr,
        input logic [15:0] msk
    );
        logic [15:0] raw;
        logic [15:0] rnd;
        begin
            raw = 16'(mf) + 16'(thr) + SCHED_OFFSET;
            rnd = (raw + msk) & ~msk;
            return rnd[13:0];
        end
    endfunction

    logic [15:0] msk;
    logic [15:0] intv;
    logic [15:0] td_calc;
    logic [5:0]  thr_start;
    logic [13:0] lo_clamp;
    logic [13:0] diff;
    logic        diff_pos;
    logic [15:0] adv;
    logic [13:0] slot_clamped;
    logic [23:0] budget;
    logic        ok;
    logic [24:0] byte_sum;

    always_comb
    begin
        msk       = ~(16'hffff << cfg.interval_log2);
        intv      = 16'd1 << cfg.interval_log2;
        td_calc   = (16'(TGT_UFRAMES) + msk) >> cfg.interval_log2;
        thr_start = cfg.threshold_raw[3] ? {cfg.threshold_raw[2:0], 3'b000}
                                         : {3'b000, cfg.threshold_raw[2:0]};

        lo_clamp = earliest_slot(item.frame_index, state.threshold_uframes, msk);
        diff     = lo_clamp - state.next_slot;
        diff_pos = (diff != 14'd0) && !diff[13];
        adv      = (16'(diff) + msk) & ~msk;
        slot_clamped = (cfg.frame_pinning && diff_pos) ? state.next_slot + adv[13:0]
                                                       : state.next_slot;

        budget   = (cfg.prefetch_limit != 24'd0) ? cfg.prefetch_limit : DEFAULT_BUDGET;
        ok       = cfg.direction_in ? (item.active_tds < state.td_target)
                                    : (state.bytes_in_flight < budget);
        byte_sum = 25'(state.bytes_in_flight) + 25'(item.byte_count);

        state_next = state;
        grant      = '0;

        case (item.action)
            ACT_START:
            begin
                state_next.threshold_uframes = thr_start;
                state_next.next_slot = earliest_slot(item.frame_index, thr_start, msk);
                state_next.td_target = td_calc[9:0];
            end
            ACT_REQUEST:
            begin
                if (ok)
                begin
                    grant.granted  = 1'b1;
                    grant.frame_id = slot_clamped[13:3];
                    state_next.next_slot = slot_clamped + intv[13:0];
                    state_next.bytes_in_flight = byte_sum[24] ? BYTES_MAX : byte_sum[23:0];
                end
            end
            ACT_COMPLETE:
            begin
                if (state.bytes_in_flight >= item.byte_count)
                begin
                    state_next.bytes_in_flight = state.bytes_in_flight - item.byte_count;
                end
            end
            default:
            begin
                state_next.bytes_in_flight = '0;
            end
        endcase
    end

endmodule

/* sv/isoch_microframe_slot_scheduler_unit.sv */
// channel  dir  handshake      payload
// req      in   valid/ready    action, frame_index, byte_count, active_tds
// res      out  valid/ready    granted, frame_id, slot_now, bytes_now, target_now
// cfg      in   cfg_we         cfg_index, cfg_data
//
// one beat per cycle sustained while res.ready holds; a beat's result is registered
// through the input register, then the result register
// the slot, byte and target update is one combinational step from input register to
// state and result registers, so back-to-back beats see each other's effect
// rst_n clears config, scheduler state and both valid flags
// a stalled result holds; the input register takes a beat while the result waits only if it is empty
module isoch_microframe_slot_scheduler_unit
    import ims_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [23:0]  cfg_data,
    ims_req_if.sink      req,
    ims_res_if.source    res
);

    cfg_t         cfg_reg;
    sched_state_t state_reg;
    sched_state_t state_next;
    item_t        s1_reg;
    logic         s1_valid_reg;
    logic         res_valid_reg;
    grant_t       grant;
    grant_t       grant_reg;
    logic         advance;
    logic         take_in;

    assign advance = s1_valid_reg && (!res_valid_reg || res.ready);
    assign take_in = req.valid && req.ready;
    assign req.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INTERVAL_LOG2:  cfg_reg.interval_log2  <= cfg_data[3:0];
                CFG_FRAME_PINNING:  cfg_reg.frame_pinning  <= cfg_data[0];
                CFG_THRESHOLD_RAW:  cfg_reg.threshold_raw  <= cfg_data[3:0];
                CFG_DIRECTION_IN:   cfg_reg.direction_in   <= cfg_data[0];
                CFG_PREFETCH_LIMIT: cfg_reg.prefetch_limit <= cfg_data;
                default:            ;
            endcase
        end
    end

    ims_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (s1_reg),
        .state_next (state_next),
        .grant      (grant)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_reg.action      <= req.action;
            s1_reg.frame_index <= req.frame_index;
            s1_reg.byte_count  <= req.byte_count;
            s1_reg.active_tds  <= req.active_tds;
        end
        if (advance)
        begin
            grant_reg <= grant;
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.granted    = grant_reg.granted;
    assign res.frame_id   = grant_reg.frame_id;
    assign res.slot_now   = state_reg.next_slot;
    assign res.bytes_now  = state_reg.bytes_in_flight;
    assign res.target_now = state_reg.td_target;

    a_refused_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.granted) |-> (res.frame_id == 11'd0))
        else $error("refused result carries a frame id");

    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_reg.action == ACT_STOP) |=> (state_reg.bytes_in_flight == 24'd0))
        else $error("stop beat left bytes in flight");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (s1_valid_reg && res_valid_reg && !res.ready))
        else $error("input stalled without a full pipeline");

    a_grant_only_request: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_reg.action != ACT_REQUEST) |=> !grant_reg.granted)
        else $error("grant on a non-request beat");

endmodule
